### rtl/ccve_pkg.sv
package ccve_pkg;

  // Queue between the classifier and the serializer (power of two).
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Input byte codes with a special treatment.
  localparam logic [7:0] B_NUL      = 8'h00;
  localparam logic [7:0] B_TAB      = 8'h09;
  localparam logic [7:0] B_LF       = 8'h0A;
  localparam logic [7:0] B_CR       = 8'h0D;
  localparam logic [7:0] B_ESC      = 8'h1B;
  localparam logic [7:0] B_SPACE    = 8'h20;
  localparam logic [7:0] B_TILDE    = 8'h7E;
  localparam logic [7:0] B_DEL      = 8'h7F;
  localparam logic [7:0] CARET_FLIP = 8'h40;

  // Output characters.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // One classified byte: up to four characters and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            msg_end;
  } entry_t;

  // Head of the queue as seen by the serializer.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {4'd0, n};
    end else begin
      r = CH_UPPER_A + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  function automatic entry_t classify(input logic [7:0] b, input logic e);
    entry_t r;
    r = '0;
    r.msg_end = e;
    case (b)
      B_NUL: begin
        r.chars[0] = CH_BSLASH; r.chars[1] = CH_ZERO; r.last_idx = 2'd1;
      end
      B_TAB: begin
        r.chars[0] = CH_BSLASH; r.chars[1] = CH_T; r.last_idx = 2'd1;
      end
      B_LF: begin
        r.chars[0] = CH_BSLASH; r.chars[1] = CH_N; r.last_idx = 2'd1;
      end
      B_CR: begin
        r.chars[0] = CH_BSLASH; r.chars[1] = CH_R; r.last_idx = 2'd1;
      end
      B_ESC: begin
        r.chars[0] = CH_BSLASH; r.chars[1] = CH_E; r.last_idx = 2'd1;
      end
      default: begin
        if (b < B_SPACE || b == B_DEL) begin
          r.chars[0] = CH_CARET;
          r.chars[1] = b ^ CARET_FLIP;
          r.last_idx = 2'd1;
        end else if (b <= B_TILDE) begin
          r.chars[0] = b;
          r.last_idx = 2'd0;
        end else begin
          r.chars[0] = CH_BSLASH;
          r.chars[1] = CH_X;
          r.chars[2] = hex_digit(b[7:4]);
          r.chars[3] = hex_digit(b[3:0]);
          r.last_idx = 2'd3;
        end
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/ccve_front.sv
module ccve_front import ccve_pkg::*; (
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_message_end,
  input  logic       q_full,
  output logic       full,
  output logic       wr_en,
  output entry_t     wr_entry
);

  // The front stalls only when the queue has no free slot.
  assign full     = q_full;
  assign wr_en    = push && !q_full;
  assign wr_entry = classify(in_byte, in_message_end);

endmodule

### rtl/ccve_queue.sv
module ccve_queue import ccve_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_entry,
  input  logic   rd_en,
  output logic   full,
  output qhead_t head
);

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full       = cnt_r == (QAW+1)'(QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.entry = mem_r[rptr_r];

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && head.valid;

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

endmodule

### rtl/ccve_back.sv
module ccve_back import ccve_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qhead_t     head,
  input  logic       pop,
  output logic       rd_en,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       out_last_of_byte,
  output logic       out_end_of_message
);

  entry_t     cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       at_last, done;

  assign at_last = idx_r == cur_r.last_idx;
  assign done    = busy_r && pop && at_last;
  // Reload in the same edge that retires the last character of a byte.
  assign rd_en   = head.valid && (!busy_r || done);

  assign empty              = !busy_r;
  assign out_char           = cur_r.chars[idx_r];
  assign out_last_of_byte   = at_last;
  assign out_end_of_message = at_last && cur_r.msg_end;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (rd_en) begin
      cur_nxt  = head.entry;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

### rtl/control_char_visible_escaper.sv
// Channel   Handshake      Word contents
// input     push / full    in_byte, in_message_end
// result    empty / pop    out_char, out_last_of_byte, out_end_of_message
//
// Each byte yields one to four characters, and the result port moves one
// character per cycle while pop stays high: one character for a printable
// byte, two for a backslash or caret escape and four for a hex escape.
// A two-entry queue sits between the classifier and the serializer, so new
// bytes are taken while earlier ones are still being spelled out.
// Reset (rst_n low at a clock edge) empties the queue and the serializer.
// A stalled result holds its word; full rises only when both queue slots
// and the serializer are occupied.
module control_char_visible_escaper import ccve_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_message_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_last_of_byte,
  output logic       out_end_of_message
);

  logic   q_full;
  logic   wr_en;
  logic   rd_en;
  entry_t wr_entry;
  qhead_t head;

  // The front classifies each accepted byte into its full escape sequence.
  ccve_front u_front (
    .push           (push),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .q_full         (q_full),
    .full           (full),
    .wr_en          (wr_en),
    .wr_entry       (wr_entry)
  );

  // The queue decouples intake from the character-rate result side.
  ccve_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .full     (q_full),
    .head     (head)
  );

  // The back end walks the characters of one entry, one word per pop.
  ccve_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .rd_en              (rd_en),
    .empty              (empty),
    .out_char           (out_char),
    .out_last_of_byte   (out_last_of_byte),
    .out_end_of_message (out_end_of_message)
  );

endmodule

### rtl/ccve_checker.sv
module ccve_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       out_last_of_byte,
  input logic       out_end_of_message
);

  // Right after a reset edge nothing is queued and intake is open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("not empty or full after reset");

  // A message end flag only appears on the closing character of a byte.
  a_eom_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_end_of_message) |-> out_last_of_byte)
    else $error("end of message on a non-final character");

  // Taking a non-final character leaves the rest of the byte waiting.
  a_byte_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_of_byte) |=> !empty)
    else $error("byte cut short");

  // A waiting word holds still until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_last_of_byte)
                          && $stable(out_end_of_message)))
    else $error("result word changed while stalled");

endmodule

bind control_char_visible_escaper ccve_checker u_ccve_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .push               (push),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_char           (out_char),
  .out_last_of_byte   (out_last_of_byte),
  .out_end_of_message (out_end_of_message)
);

### tb/sv/escape_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the escaper, spells out every accepted byte and
// compares each accepted result word against the oldest spelled character.
module escape_checker import ccve_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_message_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic       out_last_of_byte,
  input  logic       out_end_of_message,
  output int         mismatches,
  output int         chars_pending
);

  localparam logic [7:0] BACKSLASH = "\\";
  localparam logic [7:0] CARET     = "^";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       eom;
  } glyph_t;

  glyph_t spelled_chars[$];

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    string digits = "0123456789ABCDEF";
    return digits[v];
  endfunction

  // Returns how many characters the byte turns into, first one in text[0].
  function automatic int spell_byte(input logic [7:0] b, output logic [3:0][7:0] text);
    int n;
    text = '0;
    n = 2;
    case (b)
      B_NUL: begin text[0] = BACKSLASH; text[1] = "0"; end
      B_TAB: begin text[0] = BACKSLASH; text[1] = "t"; end
      B_LF:  begin text[0] = BACKSLASH; text[1] = "n"; end
      B_CR:  begin text[0] = BACKSLASH; text[1] = "r"; end
      B_ESC: begin text[0] = BACKSLASH; text[1] = "e"; end
      default: begin
        if (b < B_SPACE || b == B_DEL) begin
          text[0] = CARET;
          text[1] = b ^ 8'h40;
        end else if (b <= B_TILDE) begin
          text[0] = b;
          n = 1;
        end else begin
          text[0] = BACKSLASH;
          text[1] = "x";
          text[2] = hex_char(b[7:4]);
          text[3] = hex_char(b[3:0]);
          n = 4;
        end
      end
    endcase
    return n;
  endfunction

  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    logic [3:0][7:0] text;
    int n;
    if (!rst_n) begin
      mismatches = 0;
      spelled_chars.delete();
    end else begin
      // Results first: a word leaving now can never belong to a byte entering now.
      if (pop && !empty) begin
        got = glyph_t'{out_char, out_last_of_byte, out_end_of_message};
        if (spelled_chars.size() == 0) begin
          $display("%0t: expected no word, got char=%h last=%b eom=%b",
                   $time, got.ch, got.last, got.eom);
          mismatches++;
        end else begin
          want = spelled_chars.pop_front();
          if (got !== want) begin
            $display("%0t: expected char=%h last=%b eom=%b, got char=%h last=%b eom=%b",
                     $time, want.ch, want.last, want.eom, got.ch, got.last, got.eom);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        n = spell_byte(in_byte, text);
        for (int k = 0; k < n; k++) begin
          spelled_chars.push_back(glyph_t'{text[k], k == n - 1,
                                           (k == n - 1) & in_message_end});
        end
      end
    end
    chars_pending = spelled_chars.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

// Regression top for the control character escaper. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts and
// compares every result word.
module testbench import ccve_pkg::*;;

  // Longest stretch without any accepted word before the run is declared hung.
  // The receiver hold-off below is the longest legitimate quiet period.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  // Directed bytes: every backslash escape, both ends of the caret range,
  // DEL, both printable extremes, both hex extremes and a few mixed values.
  // Repeated entries pick up both values of the message end flag.
  localparam logic [7:0] DIRECTED [20] = '{
    8'h00, 8'h09, 8'h0A, 8'h0D, 8'h1B, 8'h01, 8'h1F, 8'h7F, 8'h7F, 8'h20,
    8'h7E, 8'h7E, 8'h80, 8'hFF, 8'hFF, 8'h41, 8'h9A, 8'h5C, 8'h5E, 8'h60
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_message_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_byte;
  logic       out_end_of_message;

  int mismatches;
  int chars_pending;

  // Stimulus shaping knobs, written only by the sender process, and the watchdog idle count.
  bit tx_gaps_on = 1'b1;
  bit rx_free = 1'b0;
  int hold_requests = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  control_char_visible_escaper dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .in_message_end     (in_message_end),
    .empty              (empty),
    .pop                (pop),
    .out_char           (out_char),
    .out_last_of_byte   (out_last_of_byte),
    .out_end_of_message (out_end_of_message)
  );

  escape_checker monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .in_message_end     (in_message_end),
    .empty              (empty),
    .pop                (pop),
    .out_char           (out_char),
    .out_last_of_byte   (out_last_of_byte),
    .out_end_of_message (out_end_of_message),
    .mismatches         (mismatches),
    .chars_pending      (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Byte mix weighted so that every escape class shows up often, while a
  // plain uniform share makes sure every bit pattern is reachable.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'($urandom_range(B_SPACE, B_TILDE));
      4: begin
        case ($urandom_range(0, 4))
          0: b = B_NUL;
          1: b = B_TAB;
          2: b = B_LF;
          3: b = B_CR;
          default: b = B_ESC;
        endcase
      end
      5: b = ($urandom_range(0, 7) == 0) ? B_DEL : 8'($urandom_range(1, 31));
      6, 7: b = 8'($urandom_range(128, 255));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Offers one byte and returns at the falling edge after it was taken.
  // Push stays high between back-to-back words, so it is only lowered when
  // a gap is actually inserted.
  task automatic send_word(input logic [7:0] b, input logic e);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_message_end <= e;
    do @(posedge clk); while (full);
    items_sent++;
    @(negedge clk);
  endtask

  // A message is a run of bytes with the end flag on the last one only.
  // An unterminated message models a sender that got cut off mid-stream.
  task automatic send_message(input int len, input bit terminated);
    for (int k = 0; k < len; k++) begin
      send_word(pick_byte(), terminated && (k == len - 1));
    end
  endtask

  // Stops offering and waits until the checker has seen every character.
  // The checker updates its count at the rising edge, so it is read at the
  // falling edge to stay clear of that update.
  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
  endtask

  // Receiver: random pop gaps, a free-running mode, and a long hold-off
  // whenever the sender asks for one so that the block backs up to full.
  initial begin
    int rx_gap;
    int hold_served;
    rx_gap = 0;
    hold_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        pop <= 1'b0;
        hold_served++;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_free) begin
        pop <= 1'b1;
      end else if (rx_gap > 0) begin
        pop <= 1'b0;
        rx_gap--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          rx_gap = pick_gap();
        end
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("control_char_visible_escaper regression: fail");
        $finish;
      end
    end
  end

  // Sender and verdict.
  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes, with the end flag alternating word by word.
    for (int k = 0; k < 20; k++) begin
      send_word(DIRECTED[k], k[0]);
    end
    drain_results();

    // Well-formed messages of random length and content.
    while (items_sent < 150) begin
      send_message($urandom_range(1, 12), 1'b1);
    end

    // The receiver holds off while the sender keeps offering back to back,
    // so the queue and serializer fill and full must hold the input off.
    hold_requests++;
    tx_gaps_on = 1'b0;
    repeat (40) send_word(pick_byte(), 1'($urandom_range(0, 1)));
    tx_gaps_on = 1'b1;
    drain_results();

    // A stretch with no idling on either side.
    rx_free = 1'b1;
    tx_gaps_on = 1'b0;
    while (items_sent < 260) begin
      send_message($urandom_range(1, 12), 1'b1);
    end
    rx_free = 1'b0;
    tx_gaps_on = 1'b1;

    // Mostly messages again, mixed with stray words and cut-off messages.
    while (items_sent < 360) begin
      case ($urandom_range(0, 5))
        0: send_word(pick_byte(), 1'($urandom_range(0, 1)));
        1: send_message($urandom_range(1, 8), 1'b0);
        default: send_message($urandom_range(1, 8), 1'b1);
      endcase
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && chars_pending == 0) begin
      $display("control_char_visible_escaper regression: pass");
    end else begin
      $display("control_char_visible_escaper regression: fail");
    end
    $finish;
  end

endmodule
